// ===== hw/rtl/vnl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnl_pkg
// Shared types, constants and helper functions of the von Neumann life core.
// ----------------------------------------------------------------------------
package vnl_pkg;

   localparam int GRID_SIZE = 64;
   localparam int ROW_W     = 64;
   localparam int COORD_W   = 6;
   localparam int CNT_W     = 7;

   localparam logic [ROW_W-1:0] COL_MASK = ROW_W'((65'd1 << GRID_SIZE) - 65'd1);

   localparam logic [2:0] SURVIVE_LO = 3'd2;
   localparam logic [2:0] BIRTH_CNT  = 3'd3;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_SET    = 2'd1,
      ACT_EVOLVE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET_WR,
      ST_EVOLVE,
      ST_LOOKUP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] max_y;
      logic [COORD_W-1:0] max_x;
      logic [COORD_W-1:0] min_y;
      logic [COORD_W-1:0] min_x;
   } box_type;

   function automatic logic [COORD_W-1:0] lowest_one(input logic [ROW_W-1:0] row);
      logic [COORD_W-1:0] r;
      r = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (row[i]) begin
            r = COORD_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] highest_one(input logic [ROW_W-1:0] row);
      logic [COORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < ROW_W; i++) begin
         if (row[i]) begin
            r = COORD_W'(i);
         end
      end
      return r;
   endfunction

   function automatic box_type box_merge(input box_type b, input logic b_valid,
                                         input logic [COORD_W-1:0] lo_x,
                                         input logic [COORD_W-1:0] hi_x,
                                         input logic [COORD_W-1:0] y);
      box_type r;
      r.min_x = lo_x;
      r.max_x = hi_x;
      r.min_y = y;
      r.max_y = y;
      if (b_valid) begin
         r.min_x = (b.min_x < lo_x) ? b.min_x : lo_x;
         r.max_x = (b.max_x > hi_x) ? b.max_x : hi_x;
         r.min_y = (b.min_y < y) ? b.min_y : y;
         r.max_y = (b.max_y > y) ? b.max_y : y;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vnl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vnl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module vnl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/von_neumann_life_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// von_neumann_life_step_core
// Life-like automaton with a four-neighbor rule on a 64 by 64 grid.
//
// A transaction is accepted on a rising edge with start high and busy low.
// The fields req_action, req_col_x and req_row_y select clear, set cell,
// evolve one generation or read cell. Each transaction returns exactly one
// result, shown for one cycle with rsp_strobe high: the cell state at the
// given coordinates after the action and the live bounding box.
// The receiver cannot stall the result; busy stays high until it is shown.
// Of clear, set and read, set is the longest, because it
// reads, modifies and writes back one row of the current plane.
// An evolve is a row sweep that reads one 64-bit row of the
// source plane per cycle over 64 rows, with a window fill,
// a registered box update and a final lookup of the addressed cell.
// The generations live in two ping-pong row memories with one valid bit
// per row, so reset and clear empty the grid at once, without a sweep.
// After reset the grid and the box are empty and plane zero is current.
// ----------------------------------------------------------------------------
module von_neumann_life_step_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_action,
   input  wire logic [vnl_pkg::COORD_W-1:0]   req_col_x,
   input  wire logic [vnl_pkg::COORD_W-1:0]   req_row_y,
   output logic                               rsp_strobe,
   output logic                               rsp_cell_alive,
   output logic [vnl_pkg::COORD_W-1:0]        rsp_box_min_x,
   output logic [vnl_pkg::COORD_W-1:0]        rsp_box_min_y,
   output logic [vnl_pkg::COORD_W-1:0]        rsp_box_max_x,
   output logic [vnl_pkg::COORD_W-1:0]        rsp_box_max_y,
   output logic                               rsp_box_empty
);

   import vnl_pkg::*;

   state_type             state_ff, state_in;
   logic [COORD_W-1:0]    x_ff, y_ff;
   logic                  cur_ff, cur_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ROW_W-1:0]      above_ff, mid_ff;
   logic [ROW_W-1:0]      nrow_ff, nrow_in;
   logic [COORD_W-1:0]    ny_ff;
   logic                  nv_ff, nv_in;
   box_type               box_ff, box_in;
   logic                  box_valid_ff, box_valid_in;
   logic [1:0][ROW_W-1:0] vbits_ff, vbits_in;
   logic                  rok_ff;

   logic [COORD_W-1:0]    rd_addr;
   logic [ROW_W-1:0]      rd_data0, rd_data1, rd_row, below;
   logic                  wr_en, wr_plane;
   logic [COORD_W-1:0]    wr_addr;
   logic [ROW_W-1:0]      wr_data;
   logic                  shift_en;
   logic                  in_grid;
   logic                  accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign in_grid = ({1'b0, x_ff} < 7'(GRID_SIZE)) && ({1'b0, y_ff} < 7'(GRID_SIZE));
   assign rd_row = (cur_ff ? rd_data1 : rd_data0) & {ROW_W{rok_ff}};
   assign below  = (cnt_ff <= CNT_W'(GRID_SIZE)) ? rd_row : '0;

   vnl_ram #(.WIDTH(ROW_W), .DEPTH(GRID_SIZE)) u_plane0 (
      .clock   (clock),
      .wr_en   (wr_en && !wr_plane),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   vnl_ram #(.WIDTH(ROW_W), .DEPTH(GRID_SIZE)) u_plane1 (
      .clock   (clock),
      .wr_en   (wr_en && wr_plane),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   always_comb begin
      logic [2:0] n;
      nrow_in = '0;
      for (int i = 0; i < ROW_W; i++) begin
         n = 3'(above_ff[i]) + 3'(below[i]);
         if (i > 0) begin
            n = n + 3'(mid_ff[i-1]);
         end
         if (i < ROW_W - 1) begin
            n = n + 3'(mid_ff[i+1]);
         end
         if (mid_ff[i]) begin
            nrow_in[i] = (n == SURVIVE_LO) || (n == BIRTH_CNT);
         end else begin
            nrow_in[i] = (n == BIRTH_CNT);
         end
      end
      nrow_in = nrow_in & COL_MASK;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      box_in       = box_ff;
      box_valid_in = box_valid_ff;
      vbits_in     = vbits_ff;
      rd_addr      = y_ff;
      wr_en        = 1'b0;
      wr_plane     = cur_ff;
      wr_addr      = y_ff;
      wr_data      = rd_row | (ROW_W'(1) << x_ff);
      shift_en     = 1'b0;
      nv_in        = 1'b0;
      rsp_strobe   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_row_y;
            if (start) begin
               unique case (action_type'(req_action))
                  ACT_CLEAR: begin
                     vbits_in     = '0;
                     box_in       = '0;
                     box_valid_in = 1'b0;
                     state_in     = ST_LOOKUP;
                  end
                  ACT_SET: begin
                     state_in = ST_SET_WR;
                  end
                  ACT_EVOLVE: begin
                     cnt_in       = '0;
                     box_in       = '0;
                     box_valid_in = 1'b0;
                     state_in     = ST_EVOLVE;
                  end
                  ACT_READ: begin
                     state_in = ST_LOOKUP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SET_WR: begin
            if (in_grid) begin
               wr_en                = 1'b1;
               vbits_in[cur_ff][y_ff] = 1'b1;
               box_in               = box_merge(box_ff, box_valid_ff, x_ff, x_ff, y_ff);
               box_valid_in         = 1'b1;
            end
            state_in = ST_LOOKUP;
         end
         ST_EVOLVE: begin
            rd_addr  = cnt_ff[COORD_W-1:0];
            shift_en = (cnt_ff >= CNT_W'(1)) && (cnt_ff <= CNT_W'(GRID_SIZE + 1));
            nv_in    = (cnt_ff >= CNT_W'(2)) && (cnt_ff <= CNT_W'(GRID_SIZE + 1));
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(GRID_SIZE + 2)) begin
               cur_in   = !cur_ff;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (nv_ff) begin
         wr_en                   = 1'b1;
         wr_plane                = !cur_ff;
         wr_addr                 = ny_ff;
         wr_data                 = nrow_ff;
         vbits_in[!cur_ff][ny_ff] = 1'b1;
         if (nrow_ff != '0) begin
            box_in       = box_merge(box_ff, box_valid_ff, lowest_one(nrow_ff),
                                     highest_one(nrow_ff), ny_ff);
            box_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= 1'b0;
         cnt_ff       <= '0;
         box_ff       <= '0;
         box_valid_ff <= 1'b0;
         vbits_ff     <= '0;
         nv_ff        <= 1'b0;
         rok_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         cnt_ff       <= cnt_in;
         box_ff       <= box_in;
         box_valid_ff <= box_valid_in;
         vbits_ff     <= vbits_in;
         nv_ff        <= nv_in;
         rok_ff       <= vbits_ff[cur_ff][rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff   <= req_col_x;
         y_ff   <= req_row_y;
      end
      if (accept) begin
         above_ff <= '0;
         mid_ff   <= '0;
      end else if (shift_en) begin
         above_ff <= mid_ff;
         mid_ff   <= below;
      end
      nrow_ff <= nrow_in;
      ny_ff   <= cnt_ff[COORD_W-1:0] - COORD_W'(2);
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_cell_alive = in_grid && rd_row[x_ff];
   assign rsp_box_min_x  = box_valid_ff ? box_ff.min_x : '0;
   assign rsp_box_min_y  = box_valid_ff ? box_ff.min_y : '0;
   assign rsp_box_max_x  = box_valid_ff ? box_ff.max_x : '0;
   assign rsp_box_max_y  = box_valid_ff ? box_ff.max_y : '0;
   assign rsp_box_empty  = !box_valid_ff;

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      box_valid_ff |-> (box_ff.min_x <= box_ff.max_x) && (box_ff.min_y <= box_ff.max_y))
      else $error("live box bounds out of order");

   a_sweep_writes_dst: assert property (@(posedge clock) disable iff (reset)
      nv_ff |-> wr_en && (wr_plane != cur_ff))
      else $error("generation sweep wrote the source plane");

   a_set_marks_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SET_WR) && in_grid |=> box_valid_ff)
      else $error("set of a cell left the box empty");

   a_flip_after_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVOLVE) && (cnt_ff == CNT_W'(GRID_SIZE + 2)) |=> cur_ff != $past(cur_ff))
      else $error("current plane did not flip after the sweep");

endmodule
`default_nettype wire
